>>> hw/rtl/heat_diffusion_stencil_pass_macros.svh
// Assertion macros shared by the heat diffusion stencil pass RTL.
`ifndef HEAT_DIFFUSION_STENCIL_PASS_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_PASS_MACROS_SVH

`ifndef SYNTHESIS

`define HDS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("hds: forbidden condition seen");

`define HDS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hds: implication failed");

`define HDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hds: next-cycle implication failed");

`else

`define HDS_ASSERT_NEVER(label, clk, rst, cond)
`define HDS_ASSERT_SAME(label, clk, rst, ante, cons)
`define HDS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/hds_pkg.sv
// Shared constants for the heat diffusion stencil pass.
`default_nettype none

package hds_pkg;

  localparam int GRID_MAX_DEFAULT = 256;

  localparam int CELL_W    = 32;
  localparam int TOTAL_W   = 48;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int SIZE_W    = 9;
  localparam int ENERGY_W  = 16;
  localparam int SOURCE_W  = 17;
  localparam int FRAC_W    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ENERGY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_A      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_B      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_C      = 3'd5;

  localparam logic [SIZE_W-1:0]   GRID_WIDTH_RESET    = 9'd256;
  localparam logic [SIZE_W-1:0]   GRID_HEIGHT_RESET   = 9'd256;
  localparam logic [ENERGY_W-1:0] SOURCE_ENERGY_RESET = 16'd1;

  localparam int OUT_DEPTH = 4;

endpackage

`default_nettype wire

>>> hw/rtl/hds_cell_if.sv
// Input channel carrying old cell words.
`default_nettype none

interface hds_cell_if;
  logic                       valid;
  logic                       ready;
  logic [hds_pkg::CELL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hds_result_if.sv
// Output channel carrying updated cell words.
`default_nettype none

interface hds_result_if;
  logic                        valid;
  logic                        ready;
  logic [hds_pkg::CELL_W-1:0]  new_value;
  logic [hds_pkg::ROW_W-1:0]   out_row;
  logic [hds_pkg::COL_W-1:0]   out_col;
  logic                        last_cell;
  logic [hds_pkg::TOTAL_W-1:0] heat_total;

  modport source (output valid, output new_value, output out_row, output out_col,
                  output last_cell, output heat_total, input ready);
  modport sink (input valid, input new_value, input out_row, input out_col,
                input last_cell, input heat_total, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hds_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface hds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hds_pkg::CFG_IDX_W-1:0]  index;
  logic [hds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/heat_diffusion_stencil_pass.sv
// Top level of the streaming Jacobi 5-point heat stencil pass.
`default_nettype none
`include "heat_diffusion_stencil_pass_macros.svh"

// Old cells enter in raster order, one word per clock, followed by one pad row. The
// block takes a new word every cycle for as long as its four-entry output queue has
// room; a result passes the stencil, result and output queue registers before it is
// visible. The rate is set by the middle line store, which is read at the centre and right
// columns and written once per word; the upper line store is read once per word and is
// written once per word after the first row. The first row yields no results; each later
// word yields the new cell one row above. A write to the line stores is forwarded to a
// read of the same column issued with it, which matters on grids one or two columns wide.
module heat_diffusion_stencil_pass #(
  parameter int GRID_MAX = hds_pkg::GRID_MAX_DEFAULT
) (
  input  wire            clk,
  input  wire            rst,
  hds_cell_if.sink       cells,
  hds_result_if.source   result,
  hds_cfg_if.sink        cfg
);

  localparam int CW = $clog2(GRID_MAX);
  localparam int RW = $clog2(GRID_MAX + 1);
  localparam int SW = RW + 1;
  localparam int QW = $clog2(hds_pkg::OUT_DEPTH);
  localparam int NW = $clog2(hds_pkg::OUT_DEPTH + 1);
  localparam int SUM_W = hds_pkg::CELL_W + 3;
  localparam int ADD_W = hds_pkg::ENERGY_W + 2;

  typedef struct packed {
    logic [hds_pkg::CELL_W-1:0] x;
    logic [CW-1:0]              c;
    logic [hds_pkg::ROW_W-1:0]  orow;
    logic                       rzero;
    logic                       top;
    logic                       czero;
    logic                       has_right;
    logic                       has_down;
    logic                       last;
    logic [2:0]                 match;
  } s1_t;

  typedef struct packed {
    logic [hds_pkg::CELL_W-1:0]  new_value;
    logic [hds_pkg::ROW_W-1:0]   out_row;
    logic [hds_pkg::COL_W-1:0]   out_col;
    logic                        last_cell;
    logic [hds_pkg::TOTAL_W-1:0] heat_total;
  } result_t;

  logic [hds_pkg::SIZE_W-1:0]   grid_width;
  logic [hds_pkg::SIZE_W-1:0]   grid_height;
  logic [hds_pkg::ENERGY_W-1:0] source_energy;
  logic [hds_pkg::SOURCE_W-1:0] source_a;
  logic [hds_pkg::SOURCE_W-1:0] source_b;
  logic [hds_pkg::SOURCE_W-1:0] source_c;

  logic [hds_pkg::CELL_W-1:0] mid_mem [GRID_MAX];
  logic [hds_pkg::CELL_W-1:0] up_mem [GRID_MAX];
  logic [hds_pkg::CELL_W-1:0] rd_c;
  logic [hds_pkg::CELL_W-1:0] rd_r;
  logic [hds_pkg::CELL_W-1:0] rd_u;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;

  logic [RW-1:0] w;
  logic [RW-1:0] h;
  logic [SW-1:0] w_ext;
  logic [SW-1:0] h_ext;
  logic [SW-1:0] c_pre;
  logic [SW-1:0] r_pre;
  logic [SW-1:0] c_inc;
  logic [SW-1:0] r_inc;
  logic [SW-1:0] orow_ext;
  logic [CW-1:0] c_idx;
  logic [CW-1:0] right_idx;
  s1_t           s1_next;

  logic                       accept;
  logic                       s1_valid;
  s1_t                        s1;
  logic                       fwd_c;
  logic                       fwd_r;
  logic                       fwd_u;
  logic [hds_pkg::CELL_W-1:0] fwd_mid_data;
  logic [hds_pkg::CELL_W-1:0] fwd_up_data;
  logic [hds_pkg::CELL_W-1:0] left_hold;

  logic [hds_pkg::CELL_W-1:0] centre;
  logic [hds_pkg::CELL_W-1:0] right_val;
  logic [hds_pkg::CELL_W-1:0] up_val;
  logic [hds_pkg::CELL_W-1:0] left_val;
  logic [hds_pkg::CELL_W-1:0] down_val;
  logic [SUM_W-1:0]           stencil_sum;
  logic [ADD_W-1:0]           src_add;

  logic                        s2_valid;
  logic [hds_pkg::CELL_W-1:0]  s2_cell;
  logic [hds_pkg::ROW_W-1:0]   s2_row;
  logic [hds_pkg::COL_W-1:0]   s2_col;
  logic                        s2_last;
  logic [ADD_W-1:0]            s2_add;
  logic [hds_pkg::TOTAL_W-1:0] heat_acc;
  logic [hds_pkg::TOTAL_W:0]   acc_sum;
  logic [hds_pkg::TOTAL_W-1:0] acc_sat;
  logic [SUM_W-1:0]            cell_sum;
  result_t                     push_entry;

  result_t       queue [hds_pkg::OUT_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [NW-1:0] q_count;
  logic          pop;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= hds_pkg::GRID_WIDTH_RESET;
      grid_height   <= hds_pkg::GRID_HEIGHT_RESET;
      source_energy <= hds_pkg::SOURCE_ENERGY_RESET;
      source_a      <= '0;
      source_b      <= '0;
      source_c      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hds_pkg::REG_GRID_WIDTH:    grid_width    <= cfg.data[hds_pkg::SIZE_W-1:0];
        hds_pkg::REG_GRID_HEIGHT:   grid_height   <= cfg.data[hds_pkg::SIZE_W-1:0];
        hds_pkg::REG_SOURCE_ENERGY: source_energy <= cfg.data[hds_pkg::ENERGY_W-1:0];
        hds_pkg::REG_SOURCE_A:      source_a      <= cfg.data;
        hds_pkg::REG_SOURCE_B:      source_b      <= cfg.data;
        hds_pkg::REG_SOURCE_C:      source_c      <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Grid sizes are used clamped to the range the line stores support.
  always_comb begin
    if (grid_width == '0) begin
      w = RW'(1);
    end else if (32'(grid_width) > 32'(GRID_MAX)) begin
      w = RW'(GRID_MAX);
    end else begin
      w = RW'(grid_width);
    end
    if (grid_height == '0) begin
      h = RW'(1);
    end else if (32'(grid_height) > 32'(GRID_MAX)) begin
      h = RW'(GRID_MAX);
    end else begin
      h = RW'(grid_height);
    end
  end

  assign w_ext = SW'(w);
  assign h_ext = SW'(h);

  // Position of the arriving word and the counters after it.
  always_comb begin
    c_pre = SW'(col_count);
    r_pre = SW'(row_count);
    if (c_pre >= w_ext) begin
      c_pre = '0;
      r_pre = r_pre + SW'(1);
    end
    if (r_pre > h_ext) begin
      r_pre = '0;
    end
    c_inc    = c_pre + SW'(1);
    r_inc    = r_pre + SW'(1);
    orow_ext = r_pre - SW'(1);
    if (c_inc >= w_ext) begin
      col_count_next = '0;
      row_count_next = (r_inc > h_ext) ? '0 : RW'(r_inc);
    end else begin
      col_count_next = CW'(c_inc);
      row_count_next = RW'(r_pre);
    end
    c_idx     = CW'(c_pre);
    right_idx = CW'(c_inc);

    s1_next.x         = cells.cell_value;
    s1_next.c         = c_idx;
    s1_next.orow      = hds_pkg::ROW_W'(orow_ext);
    s1_next.rzero     = (r_pre == '0);
    s1_next.top       = (r_pre == SW'(1));
    s1_next.czero     = (c_pre == '0);
    s1_next.has_right = (c_inc < w_ext);
    s1_next.has_down  = (r_pre < h_ext);
    s1_next.last      = (r_pre == h_ext) && (c_inc == w_ext);
    s1_next.match[0]  = source_a[16] && (32'(source_a[15:8]) == 32'(orow_ext)) &&
                        (32'(source_a[7:0]) == 32'(c_pre));
    s1_next.match[1]  = source_b[16] && (32'(source_b[15:8]) == 32'(orow_ext)) &&
                        (32'(source_b[7:0]) == 32'(c_pre));
    s1_next.match[2]  = source_c[16] && (32'(source_c[15:8]) == 32'(orow_ext)) &&
                        (32'(source_c[7:0]) == 32'(c_pre));
  end

  assign pop    = result.valid && result.ready;
  assign cells.ready = (32'(q_count) + 32'(s1_valid) + 32'(s2_valid)) < 32'(hds_pkg::OUT_DEPTH);
  assign accept = cells.valid && cells.ready;

  // Line stores: reads on acceptance, writes back in the following cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_c <= mid_mem[c_idx];
      rd_r <= mid_mem[right_idx];
      rd_u <= up_mem[c_idx];
    end
    if (s1_valid) begin
      mid_mem[s1.c] <= s1.x;
      if (!s1.rzero) begin
        up_mem[s1.c] <= centre;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
      fwd_c     <= 1'b0;
      fwd_r     <= 1'b0;
      fwd_u     <= 1'b0;
      left_hold <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        fwd_c     <= s1_valid && (s1.c == c_idx);
        fwd_r     <= s1_valid && (s1.c == right_idx);
        fwd_u     <= s1_valid && !s1.rzero && (s1.c == c_idx);
      end
      if (s1_valid && !s1.rzero) begin
        left_hold <= centre;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1           <= s1_next;
      fwd_mid_data <= s1.x;
      fwd_up_data  <= centre;
    end
  end

  // Stencil stage.
  always_comb begin
    centre    = fwd_c ? fwd_mid_data : rd_c;
    right_val = s1.has_right ? (fwd_r ? fwd_mid_data : rd_r) : '0;
    up_val    = s1.top ? '0 : (fwd_u ? fwd_up_data : rd_u);
    left_val  = s1.czero ? '0 : left_hold;
    down_val  = s1.has_down ? s1.x : '0;
    stencil_sum = {1'b0, centre, 2'b00} + SUM_W'(left_val) + SUM_W'(right_val) +
                  SUM_W'(up_val) + SUM_W'(down_val);
    case (s1.match) inside
      3'b000:                 src_add = '0;
      3'b001, 3'b010, 3'b100: src_add = ADD_W'(source_energy);
      3'b111:                 src_add = ADD_W'(source_energy) + {1'b0, source_energy, 1'b0};
      default:                src_add = {1'b0, source_energy, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && !s1.rzero;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_cell <= stencil_sum[SUM_W-1:3];
      s2_row  <= s1.orow;
      s2_col  <= hds_pkg::COL_W'(s1.c);
      s2_last <= s1.last;
      s2_add  <= src_add;
    end
  end

  // Heat total and source energy.
  always_comb begin
    acc_sum  = {1'b0, heat_acc} + (hds_pkg::TOTAL_W + 1)'(s2_cell);
    acc_sat  = acc_sum[hds_pkg::TOTAL_W] ? '1 : acc_sum[hds_pkg::TOTAL_W-1:0];
    cell_sum = SUM_W'(s2_cell) + SUM_W'({s2_add, {hds_pkg::FRAC_W{1'b0}}});
    push_entry.new_value  = (cell_sum[SUM_W-1:hds_pkg::CELL_W] != '0) ? '1
                          : cell_sum[hds_pkg::CELL_W-1:0];
    push_entry.out_row    = s2_row;
    push_entry.out_col    = s2_col;
    push_entry.last_cell  = s2_last;
    push_entry.heat_total = s2_last ? acc_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_acc <= '0;
    end else if (s2_valid) begin
      heat_acc <= s2_last ? '0 : acc_sat;
    end
  end

  // Output queue.
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      queue[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      if (s2_valid && !pop) begin
        q_count <= q_count + NW'(1);
      end else if (pop && !s2_valid) begin
        q_count <= q_count - NW'(1);
      end
    end
  end

  assign result.valid      = (q_count != '0);
  assign result.new_value  = queue[rd_ptr].new_value;
  assign result.out_row    = queue[rd_ptr].out_row;
  assign result.out_col    = queue[rd_ptr].out_col;
  assign result.last_cell  = queue[rd_ptr].last_cell;
  assign result.heat_total = queue[rd_ptr].heat_total;

  `HDS_ASSERT_NEVER(a_queue_no_overflow, clk, rst,
    s2_valid && !pop && (32'(q_count) == 32'(hds_pkg::OUT_DEPTH)))
  `HDS_ASSERT_NEXT(a_accept_enters_stencil, clk, rst, accept, s1_valid)
  `HDS_ASSERT_NEXT(a_total_clears_at_last, clk, rst, s2_valid && s2_last, heat_acc == '0)

endmodule

`default_nettype wire
